FILE: design/ltpd_pkg.sv
// Shared types, packet codes and the length table of the packet deframer.
package ltpd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 11;
  localparam int unsigned DIM_W  = 16;
  localparam int unsigned ADDR_W = 48;
  // (y*size_z + z) stays below 2^32, times size_x plus x stays below 2^48
  localparam int unsigned P1_W   = 2 * DIM_W;
  localparam int unsigned P2_W   = ADDR_W;

  // packet ids with special handling
  localparam logic [BYTE_W-1:0] ID_LEVEL_INIT = 8'h02;
  localparam logic [BYTE_W-1:0] ID_LEVEL_END  = 8'h04;
  localparam logic [BYTE_W-1:0] ID_SET_BLOCK  = 8'h06;

  // total packet length, id byte included, for ids 0x00..0x0f
  localparam logic [LEN_W-1:0] LEN_TABLE [16] = '{
    11'd131, 11'd1, 11'd1, 11'd1028, 11'd7, 11'd0, 11'd8, 11'd74,
    11'd10,  11'd7, 11'd5, 11'd4,    11'd2, 11'd66, 11'd65, 11'd2
  };

  // controller to datapath commands
  typedef struct packed {
    logic take;      // input transfer this cycle
    logic load_pkt;  // load result of a non-block-write packet completed by this transfer
    logic mul1;      // first multiply step of a block write
    logic load_sb;   // load block write result
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic done;      // the byte on the input would complete a packet
    logic setblock;  // ... and that packet is a block write
  } stat_t;

  function automatic logic [LEN_W-1:0] len_of(input logic [BYTE_W-1:0] id);
    logic [LEN_W-1:0] len;
    len = '0;
    if (id[BYTE_W-1:4] == '0) begin
      len = LEN_TABLE[id[3:0]];
    end
    return len;
  endfunction

endpackage

FILE: design/ltpd_ctrl.sv
// Controller of the packet deframer: byte intake, multiply sequencing, result valid.
module ltpd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  ltpd_pkg::stat_t stat,
  output ltpd_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_BYTE = 3'b001,
    ST_MUL1 = 3'b010,
    ST_MUL2 = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // result register can take a new value this cycle
  assign out_free = !out_valid_r || out_ready;

  // bytes that do not complete a packet pass even while a result waits
  assign in_ready = (state_r == ST_BYTE) && (out_free || !stat.done);

  always_comb begin
    cmd.take     = in_valid && in_ready;
    cmd.load_pkt = cmd.take && stat.done && !stat.setblock;
    cmd.mul1     = (state_r == ST_MUL1);
    cmd.load_sb  = (state_r == ST_MUL2) && out_free;
  end

  // state sequencing
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_BYTE: begin
        if (cmd.take && stat.setblock) state_nxt = ST_MUL1;
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: begin
        if (out_free) state_nxt = ST_BYTE;
      end
      default: state_nxt = ST_BYTE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_pkt || cmd.load_sb) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_BYTE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: design/ltpd_datapath.sv
// Datapath of the packet deframer: byte counter, field capture, dimensions, address.
module ltpd_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ltpd_pkg::BYTE_W-1:0]   in_data_byte,
  input  ltpd_pkg::cmd_t                cmd,
  output ltpd_pkg::stat_t               stat,
  output logic [ltpd_pkg::BYTE_W-1:0]   out_frame_id,
  output logic                          out_unknown_id,
  output logic                          out_write_valid,
  output logic [ltpd_pkg::ADDR_W-1:0]   out_write_address,
  output logic [ltpd_pkg::BYTE_W-1:0]   out_block_value,
  output logic [ltpd_pkg::DIM_W-1:0]    out_size_x,
  output logic [ltpd_pkg::DIM_W-1:0]    out_size_y,
  output logic [ltpd_pkg::DIM_W-1:0]    out_size_z
);

  localparam int unsigned BW  = ltpd_pkg::BYTE_W;
  localparam int unsigned LW  = ltpd_pkg::LEN_W;
  localparam int unsigned DW  = ltpd_pkg::DIM_W;
  localparam int unsigned PW1 = ltpd_pkg::P1_W;
  localparam int unsigned PW2 = ltpd_pkg::P2_W;

  // packet tracking
  logic [LW-1:0] idx_r, idx_nxt;
  logic [LW-1:0] cur_len_r;
  logic [BW-1:0] cur_id_r;
  logic [LW-1:0] tbl_len, idx_inc;
  logic [BW-1:0] pkt_id;
  logic          unknown;

  // captured fields and stored dimensions
  logic [DW-1:0] fa_r, fb_r, fc_r, fa_nxt, fb_nxt, fc_nxt;
  logic [BW-1:0] fblk_r, fblk_nxt;
  logic [DW-1:0] dx_r, dy_r, dz_r, dx_nxt, dy_nxt, dz_nxt;

  // address multiply
  logic [PW1-1:0] p1_r;
  logic [PW2-1:0] p2;
  logic           in_map;

  // result register
  logic [BW-1:0]                 res_id_r;
  logic                          res_unk_r, res_wv_r;
  logic [ltpd_pkg::ADDR_W-1:0]   res_addr_r;
  logic [BW-1:0]                 res_blk_r;
  logic [DW-1:0]                 res_sx_r, res_sy_r, res_sz_r;

  // completion decode for the byte on the input
  always_comb begin
    tbl_len = ltpd_pkg::len_of(in_data_byte);
    idx_inc = idx_r + LW'(1);
    if (idx_r == '0) begin
      pkt_id    = in_data_byte;
      unknown   = (tbl_len == '0);
      stat.done = (tbl_len <= LW'(1));
      idx_nxt   = stat.done ? '0 : LW'(1);
    end else begin
      pkt_id    = cur_id_r;
      unknown   = 1'b0;
      stat.done = (idx_inc == cur_len_r);
      idx_nxt   = stat.done ? '0 : idx_inc;
    end
    stat.setblock = stat.done && !unknown && (pkt_id == ltpd_pkg::ID_SET_BLOCK);
  end

  // big-endian field capture at packet bytes 1..7
  always_comb begin
    fa_nxt   = fa_r;
    fb_nxt   = fb_r;
    fc_nxt   = fc_r;
    fblk_nxt = fblk_r;
    case (idx_r)
      LW'(1): fa_nxt   = {in_data_byte, fa_r[7:0]};
      LW'(2): fa_nxt   = {fa_r[15:8], in_data_byte};
      LW'(3): fb_nxt   = {in_data_byte, fb_r[7:0]};
      LW'(4): fb_nxt   = {fb_r[15:8], in_data_byte};
      LW'(5): fc_nxt   = {in_data_byte, fc_r[7:0]};
      LW'(6): fc_nxt   = {fc_r[15:8], in_data_byte};
      LW'(7): fblk_nxt = in_data_byte;
      default: ;
    endcase
  end

  // dimension update on a completed level packet
  always_comb begin
    dx_nxt = dx_r;
    dy_nxt = dy_r;
    dz_nxt = dz_r;
    if (stat.done && !unknown) begin
      if (pkt_id == ltpd_pkg::ID_LEVEL_INIT) begin
        dx_nxt = '0;
        dy_nxt = '0;
        dz_nxt = '0;
      end else if (pkt_id == ltpd_pkg::ID_LEVEL_END) begin
        dx_nxt = fa_nxt;
        dy_nxt = fb_nxt;
        dz_nxt = fc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      cur_len_r <= '0;
      cur_id_r  <= '0;
      dx_r      <= '0;
      dy_r      <= '0;
      dz_r      <= '0;
    end else if (cmd.take) begin
      idx_r <= idx_nxt;
      if (idx_r == '0) begin
        cur_id_r  <= in_data_byte;
        cur_len_r <= tbl_len;
      end
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      dz_r <= dz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      fa_r   <= fa_nxt;
      fb_r   <= fb_nxt;
      fc_r   <= fc_nxt;
      fblk_r <= fblk_nxt;
    end
  end

  // first step: y*size_z + z
  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      p1_r <= PW1'(fb_r) * PW1'(dz_r) + PW1'(fc_r);
    end
  end

  // second step: (y*size_z + z)*size_x + x, with the bounds check
  assign p2     = PW2'(p1_r) * PW2'(dx_r) + PW2'(fa_r);
  assign in_map = (fa_r < dx_r) && (fb_r < dy_r) && (fc_r < dz_r);

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_pkt) begin
      res_id_r   <= pkt_id;
      res_unk_r  <= unknown;
      res_wv_r   <= 1'b0;
      res_addr_r <= '0;
      res_blk_r  <= '0;
      res_sx_r   <= dx_nxt;
      res_sy_r   <= dy_nxt;
      res_sz_r   <= dz_nxt;
    end else if (cmd.load_sb) begin
      res_id_r   <= ltpd_pkg::ID_SET_BLOCK;
      res_unk_r  <= 1'b0;
      res_wv_r   <= in_map;
      res_addr_r <= in_map ? p2 : '0;
      res_blk_r  <= in_map ? fblk_r : '0;
      res_sx_r   <= dx_r;
      res_sy_r   <= dy_r;
      res_sz_r   <= dz_r;
    end
  end

  assign out_frame_id      = res_id_r;
  assign out_unknown_id    = res_unk_r;
  assign out_write_valid   = res_wv_r;
  assign out_write_address = res_addr_r;
  assign out_block_value   = res_blk_r;
  assign out_size_x        = res_sx_r;
  assign out_size_y        = res_sy_r;
  assign out_size_z        = res_sz_r;

endmodule

FILE: design/length_table_packet_deframer_unit.sv
// Top level of the length-table packet deframer: controller, datapath and checks.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  in      | input     | in_valid / in_ready  | in_data_byte
//  out     | output    | out_valid / out_ready| out_frame_id, out_unknown_id,
//          |           |                      | out_write_valid, out_write_address,
//          |           |                      | out_block_value, out_size_x/y/z
//
// One byte is taken per cycle. After the last byte of a block write packet the
// two-step address multiply runs in states ST_MUL1 and ST_MUL2, during which no byte is taken.
// A finished result sits in the output register; bytes that do not complete a
// packet keep flowing while it waits, a completing byte waits for it to go.
// Synchronous active-low reset returns to awaiting an id byte with zero dimensions.
module length_table_packet_deframer_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ltpd_pkg::BYTE_W-1:0]   in_data_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ltpd_pkg::BYTE_W-1:0]   out_frame_id,
  output logic                          out_unknown_id,
  output logic                          out_write_valid,
  output logic [ltpd_pkg::ADDR_W-1:0]   out_write_address,
  output logic [ltpd_pkg::BYTE_W-1:0]   out_block_value,
  output logic [ltpd_pkg::DIM_W-1:0]    out_size_x,
  output logic [ltpd_pkg::DIM_W-1:0]    out_size_y,
  output logic [ltpd_pkg::DIM_W-1:0]    out_size_z
);

  ltpd_pkg::cmd_t  cmd;
  ltpd_pkg::stat_t stat;

  ltpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ltpd_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_data_byte      (in_data_byte),
    .cmd               (cmd),
    .stat              (stat),
    .out_frame_id      (out_frame_id),
    .out_unknown_id    (out_unknown_id),
    .out_write_valid   (out_write_valid),
    .out_write_address (out_write_address),
    .out_block_value   (out_block_value),
    .out_size_x        (out_size_x),
    .out_size_y        (out_size_y),
    .out_size_z        (out_size_z)
  );

  // block write holds off input during the address multiply
  a_mul_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take && stat.setblock) |=> (!in_ready ##1 !in_ready))
    else $error("input taken during address multiply");

  // a write only ever comes from a known block write packet
  a_wv_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_write_valid) |->
      (out_frame_id == ltpd_pkg::ID_SET_BLOCK && !out_unknown_id))
    else $error("write flagged on a non block write result");

  // no write means zero address and block value
  a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_write_valid) |->
      (out_write_address == '0 && out_block_value == '0))
    else $error("address or block value set without a write");

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the length-table packet deframer: stimulus, scoreboard, checks.
`timescale 1ns / 1ps

// One completed packet as seen on the result channel
typedef struct {
  logic [ltpd_pkg::BYTE_W-1:0] frame_id;
  logic                        unknown_id;
  logic                        write_valid;
  logic [ltpd_pkg::ADDR_W-1:0] write_address;
  logic [ltpd_pkg::BYTE_W-1:0] block_value;
  logic [ltpd_pkg::DIM_W-1:0]  size_x;
  logic [ltpd_pkg::DIM_W-1:0]  size_y;
  logic [ltpd_pkg::DIM_W-1:0]  size_z;
} deframe_result_t;

// Tracks the framing of the byte stream and queues the packet results it implies
class deframe_scoreboard;
  bit [ltpd_pkg::LEN_W-1:0]  byte_pos;
  bit [ltpd_pkg::BYTE_W-1:0] pkt_id;
  bit [ltpd_pkg::LEN_W-1:0]  pkt_len;
  bit [ltpd_pkg::DIM_W-1:0]  word_x, word_y, word_z;
  bit [ltpd_pkg::BYTE_W-1:0] word_block;
  bit [ltpd_pkg::DIM_W-1:0]  size_x, size_y, size_z;
  deframe_result_t           pending_q[$];
  int unsigned               mismatches;

  // total packet length by id, id byte included; zero for ids with no entry
  function bit [ltpd_pkg::LEN_W-1:0] table_length(bit [ltpd_pkg::BYTE_W-1:0] id);
    bit [ltpd_pkg::LEN_W-1:0] lengths [16];
    lengths = '{11'd131, 11'd1, 11'd1, 11'd1028, 11'd7, 11'd0, 11'd8, 11'd74,
                11'd10, 11'd7, 11'd5, 11'd4, 11'd2, 11'd66, 11'd65, 11'd2};
    if (id > 8'd15) return '0;
    return lengths[id[3:0]];
  endfunction

  // note one accepted byte; queue a result if it completes a packet
  function void note_byte(bit [ltpd_pkg::BYTE_W-1:0] b);
    bit              skipped;
    deframe_result_t res;
    bit [63:0]       prod;
    skipped = 1'b0;
    if (byte_pos == 0) begin
      pkt_id  = b;
      pkt_len = table_length(b);
      if (pkt_len == 0) skipped = 1'b1;
      else byte_pos = 11'd1;
    end else begin
      // big-endian words from bytes 1..6, block byte at 7
      case (byte_pos)
        1: word_x[15:8] = b;
        2: word_x[7:0]  = b;
        3: word_y[15:8] = b;
        4: word_y[7:0]  = b;
        5: word_z[15:8] = b;
        6: word_z[7:0]  = b;
        7: word_block   = b;
        default: ;
      endcase
      byte_pos++;
    end
    if (!skipped && byte_pos < pkt_len) return;

    byte_pos          = '0;
    res.frame_id      = pkt_id;
    res.unknown_id    = skipped;
    res.write_valid   = 1'b0;
    res.write_address = '0;
    res.block_value   = '0;
    if (!skipped) begin
      if (pkt_id == ltpd_pkg::ID_LEVEL_INIT) begin
        size_x = '0;
        size_y = '0;
        size_z = '0;
      end else if (pkt_id == ltpd_pkg::ID_LEVEL_END) begin
        size_x = word_x;
        size_y = word_y;
        size_z = word_z;
      end else if (pkt_id == ltpd_pkg::ID_SET_BLOCK && word_x < size_x &&
                   word_y < size_y && word_z < size_z) begin
        prod = (64'(word_y) * size_z + word_z) * size_x + word_x;
        res.write_valid   = 1'b1;
        res.write_address = prod[ltpd_pkg::ADDR_W-1:0];
        res.block_value   = word_block;
      end
    end
    res.size_x = size_x;
    res.size_y = size_y;
    res.size_z = size_z;
    pending_q.push_back(res);
  endfunction

  function void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // compare one result transfer with the oldest outstanding packet
  function void check_result(deframe_result_t got);
    deframe_result_t want;
    if (pending_q.size() == 0) begin
      $error("result transfer with no packet outstanding, frame_id %0h", got.frame_id);
      mismatches++;
      return;
    end
    want = pending_q.pop_front();
    compare_field("frame_id", want.frame_id, got.frame_id);
    compare_field("unknown_id", want.unknown_id, got.unknown_id);
    compare_field("write_valid", want.write_valid, got.write_valid);
    compare_field("write_address", want.write_address, got.write_address);
    compare_field("block_value", want.block_value, got.block_value);
    compare_field("size_x", want.size_x, got.size_x);
    compare_field("size_y", want.size_y, got.size_y);
    compare_field("size_z", want.size_z, got.size_z);
  endfunction
endclass

module tb_top;

  localparam logic [ltpd_pkg::BYTE_W-1:0] ID_PING       = 8'h01;
  localparam logic [ltpd_pkg::BYTE_W-1:0] ID_LONG_PKT   = 8'h03;
  localparam logic [ltpd_pkg::BYTE_W-1:0] ID_EMPTY_SLOT = 8'h05;
  localparam int unsigned COUNTED_BYTES = 1200;

  typedef enum {RX_FREE, RX_COIN, RX_SPARSE, RX_LONG_STALL} rx_mode_t;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic [ltpd_pkg::BYTE_W-1:0] in_data_byte;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [ltpd_pkg::BYTE_W-1:0] out_frame_id;
  logic                        out_unknown_id;
  logic                        out_write_valid;
  logic [ltpd_pkg::ADDR_W-1:0] out_write_address;
  logic [ltpd_pkg::BYTE_W-1:0] out_block_value;
  logic [ltpd_pkg::DIM_W-1:0]  out_size_x;
  logic [ltpd_pkg::DIM_W-1:0]  out_size_y;
  logic [ltpd_pkg::DIM_W-1:0]  out_size_z;

  deframe_scoreboard sb;
  int unsigned       burst_left = 0;
  rx_mode_t          rx_mode    = RX_FREE;
  int unsigned       rx_left    = 0;
  int unsigned       rx_tick    = 0;

  always #6 clk = ~clk;

  length_table_packet_deframer_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_id      (out_frame_id),
    .out_unknown_id    (out_unknown_id),
    .out_write_valid   (out_write_valid),
    .out_write_address (out_write_address),
    .out_block_value   (out_block_value),
    .out_size_x        (out_size_x),
    .out_size_y        (out_size_y),
    .out_size_z        (out_size_z)
  );

  // send one byte in the current burst, idling between bursts
  task automatic put_byte(input bit [ltpd_pkg::BYTE_W-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_byte(b);
  endtask

  // coordinate mostly inside the map, sometimes on its edge or anywhere
  function automatic bit [ltpd_pkg::DIM_W-1:0] pick_coord(bit [ltpd_pkg::DIM_W-1:0] lim);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (lim != 0 && r < 7) return 16'($urandom_range(0, lim - 1));
    if (r < 8) return lim;
    return 16'($urandom);
  endfunction

  // result channel: stall pattern switches among four randomly drawn modes
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 150);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_FREE:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= (rx_tick % 4 == 0);
      default:   out_ready <= (rx_tick % 24 >= 18);
    endcase
  end

  // check every result transfer
  always @(posedge clk) begin : check_out
    deframe_result_t got;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      got.frame_id      = out_frame_id;
      got.unknown_id    = out_unknown_id;
      got.write_valid   = out_write_valid;
      got.write_address = out_write_address;
      got.block_value   = out_block_value;
      got.size_x        = out_size_x;
      got.size_y        = out_size_y;
      got.size_z        = out_size_z;
      sb.check_result(got);
    end
  end

  // stimulus
  initial begin
    bit [ltpd_pkg::BYTE_W-1:0] seq[$];
    bit [ltpd_pkg::BYTE_W-1:0] id;
    bit [ltpd_pkg::DIM_W-1:0]  d;
    int unsigned               counted;
    int unsigned               pick;
    int unsigned               n;
    bit                        long_sent;
    bit                        paused;

    sb           = new();
    counted      = 0;
    long_sent    = 1'b0;
    paused       = 1'b0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: unknown ids, ping, block write before any map, full-size map,
    // block write at the far corner, then level init
    seq = {ID_EMPTY_SLOT, 8'hFF, 8'h10, ID_PING,
           ltpd_pkg::ID_SET_BLOCK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7F,
           ltpd_pkg::ID_LEVEL_END, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
           ltpd_pkg::ID_SET_BLOCK, 8'hFF, 8'hFE, 8'hFF, 8'hFE, 8'hFF, 8'hFE, 8'hFF,
           ltpd_pkg::ID_LEVEL_INIT};
    foreach (seq[i]) put_byte(seq[i]);

    // random packets until the byte budget is spent
    while (counted < COUNTED_BYTES) begin
      if (!paused && counted >= COUNTED_BYTES / 8) begin
        // hold the sender until every result is out
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending_q.size() != 0);
        paused = 1'b1;
      end
      seq.delete();
      pick = $urandom_range(0, 99);
      if (!long_sent && counted >= COUNTED_BYTES / 8) begin
        // the one maximum-length packet
        seq.push_back(ID_LONG_PKT);
        repeat (1027) seq.push_back(8'($urandom));
        long_sent = 1'b1;
      end else if (pick < 8) begin
        // noise, may break the framing
        n = $urandom_range(1, 3);
        repeat (n) seq.push_back(8'($urandom));
      end else if (pick < 13) begin
        id = 8'($urandom_range(16, 255));
        seq.push_back(pick[0] ? ID_EMPTY_SLOT : id);
      end else if (pick < 25) begin
        seq.push_back(ltpd_pkg::ID_LEVEL_END);
        repeat (3) begin
          n = $urandom_range(0, 9);
          if (n == 0) d = '0;
          else if (n == 1) d = '1;
          else if (n == 2) d = 16'($urandom);
          else d = 16'($urandom_range(1, 8));
          seq.push_back(d[15:8]);
          seq.push_back(d[7:0]);
        end
      end else if (pick < 55) begin
        seq.push_back(ltpd_pkg::ID_SET_BLOCK);
        d = pick_coord(sb.size_x);
        seq.push_back(d[15:8]);
        seq.push_back(d[7:0]);
        d = pick_coord(sb.size_y);
        seq.push_back(d[15:8]);
        seq.push_back(d[7:0]);
        d = pick_coord(sb.size_z);
        seq.push_back(d[15:8]);
        seq.push_back(d[7:0]);
        seq.push_back(8'($urandom));
      end else if (pick < 60) begin
        seq.push_back(ltpd_pkg::ID_LEVEL_INIT);
      end else if (pick < 65) begin
        seq.push_back(ID_PING);
      end else begin
        // plain packets whose content is only counted
        do id = 8'($urandom_range(0, 15));
        while (id inside {ID_PING, ltpd_pkg::ID_LEVEL_INIT, ID_LONG_PKT,
                          ltpd_pkg::ID_LEVEL_END, ID_EMPTY_SLOT, ltpd_pkg::ID_SET_BLOCK});
        seq.push_back(id);
        repeat (sb.table_length(id) - 1) seq.push_back(8'($urandom));
      end
      foreach (seq[i]) begin
        put_byte(seq[i]);
        counted++;
      end
    end

    // drain, then allow for the multiply and output register
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_q.size() != 0);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
